@@ hdl/pdc_pkg.sv @@
// Shared constants, register codes and stage payload types of the PID duty controller.
`default_nettype none

package pdc_pkg;

  localparam int VOLT_BITS  = 11;
  localparam int ERR_W      = VOLT_BITS + 1;
  localparam int DERR_W     = VOLT_BITS + 2;
  localparam int GAIN_W     = 8;
  localparam int DUTY_W     = 10;
  localparam int INTEG_W    = 32;
  localparam int CFG_W      = (VOLT_BITS > DUTY_W) ? VOLT_BITS : DUTY_W;
  localparam int CFG_ADDR_W = 3;

  localparam int KP_W  = GAIN_W + 1 + ERR_W;
  localparam int KI_W  = GAIN_W + 1 + INTEG_W;
  localparam int KD_W  = GAIN_W + 1 + DERR_W;
  localparam int SUM_W = KI_W + 2;

  localparam int PID_SCALE   = 100;
  localparam int CORR_LIMIT  = (1 << DUTY_W) * PID_SCALE;
  localparam int MAG_W       = $clog2(CORR_LIMIT);
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 18;
  localparam int PROD_W      = MAG_W + RECIP_W;
  localparam int Q_W         = DUTY_W + 1;
  localparam int NEXT_W      = DUTY_W + 3;

  localparam logic [RECIP_W-1:0] RECIP_MUL =
    RECIP_W'(((1 << RECIP_SHIFT) + PID_SCALE - 1) / PID_SCALE);
  localparam logic [Q_W-1:0] Q_SAT = Q_W'(1 << DUTY_W);

  localparam logic [VOLT_BITS-1:0] SETPOINT_RST  = VOLT_BITS'(550);
  localparam logic [VOLT_BITS-1:0] TOLERANCE_RST = VOLT_BITS'(50);
  localparam logic [GAIN_W-1:0]    KP_RST        = GAIN_W'(5);
  localparam logic [GAIN_W-1:0]    KI_RST        = GAIN_W'(2);
  localparam logic [GAIN_W-1:0]    KD_RST        = GAIN_W'(3);
  localparam logic [DUTY_W-1:0]    DUTY_MAX_RST  = DUTY_W'(255);

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SETPOINT  = 3'd0,
    REG_TOLERANCE = 3'd1,
    REG_KP        = 3'd2,
    REG_KI        = 3'd3,
    REG_KD        = 3'd4,
    REG_DUTY_MAX  = 3'd5
  } pdc_reg_t;

  typedef struct packed {
    logic [VOLT_BITS-1:0] setpoint;
    logic [VOLT_BITS-1:0] tolerance;
    logic [GAIN_W-1:0]    kp;
    logic [GAIN_W-1:0]    ki;
    logic [GAIN_W-1:0]    kd;
    logic [DUTY_W-1:0]    duty_max;
  } pdc_cfg_t;

  typedef struct packed {
    logic              is_test;
    logic              test_active;
    logic              test_done;
    logic [DUTY_W-1:0] ramp_duty;
  } pdc_test_t;

  typedef struct packed {
    pdc_test_t                  test;
    logic signed [ERR_W-1:0]    err;
    logic signed [DERR_W-1:0]   derr;
    logic signed [INTEG_W-1:0]  integ;
  } pdc_ctrl_t;

  typedef struct packed {
    pdc_test_t          test;
    logic               neg;
    logic [Q_W-1:0]     q_mag;
  } pdc_corr_t;

endpackage

`default_nettype wire

@@ hdl/pdc_ctrl_stage.sv @@
// Input register, ramp test sequencer and error/integral state update.
`default_nettype none

module pdc_ctrl_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pdc_pkg::pdc_cfg_t             cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pdc_pkg::VOLT_BITS-1:0] meas,
  input  logic                          start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pdc_pkg::pdc_ctrl_t            out_data
);
  import pdc_pkg::*;

  logic                       in_v_r;
  logic [VOLT_BITS-1:0]       meas_r;
  logic                       start_r;
  logic                       test_r, test_nxt;
  logic [DUTY_W-1:0]          ramp_r, ramp_nxt;
  logic [1:0]                 div_r, div_nxt;
  logic signed [ERR_W-1:0]    prev_err_r, prev_err_nxt;
  logic signed [INTEG_W-1:0]  integ_r, integ_nxt;
  logic                       out_v_r;
  pdc_ctrl_t                  out_r;

  logic                       rdy_out;
  logic                       move;
  logic                       run;
  logic [DUTY_W-1:0]          base;
  logic [DUTY_W-1:0]          ramp_duty;
  logic                       done;
  logic signed [ERR_W-1:0]    err;
  logic signed [DERR_W-1:0]   derr;
  logic [INTEG_W:0]           integ_sum;
  logic signed [INTEG_W-1:0]  integ_sat;
  logic signed [INTEG_W-1:0]  integ_new;
  logic                       below_tol;
  pdc_ctrl_t                  data;

  assign rdy_out  = !out_v_r || out_ready;
  assign in_ready = !in_v_r || rdy_out;
  assign move     = in_v_r && rdy_out;

  assign run  = test_r || start_r;
  assign base = test_r ? ramp_r : '0;

  assign err  = $signed({1'b0, cfg.setpoint}) - $signed({1'b0, meas_r});
  assign derr = {err[ERR_W-1], err} - {prev_err_r[ERR_W-1], prev_err_r};
  assign below_tol = err < $signed({1'b0, cfg.tolerance});

  assign integ_sum = {integ_r[INTEG_W-1], integ_r} +
                     {{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err};

  always_comb begin
    case (integ_sum[INTEG_W:INTEG_W-1])
      2'b01:   integ_sat = INTEG_MAX;
      2'b10:   integ_sat = INTEG_MIN;
      default: integ_sat = integ_sum[INTEG_W-1:0];
    endcase
  end

  assign integ_new = below_tol ? '0 : integ_sat;

  always_comb begin
    test_nxt     = test_r;
    div_nxt      = div_r;
    prev_err_nxt = prev_err_r;
    integ_nxt    = integ_r;
    done         = 1'b0;
    ramp_duty    = base;
    if (run) begin
      if (base < cfg.duty_max) begin
        test_nxt = 1'b1;
        if (div_r == 2'd0 || div_r == 2'd1) begin
          div_nxt = div_r + 2'd1;
        end else begin
          ramp_duty = base + DUTY_W'(1);
          div_nxt   = 2'd0;
        end
      end else begin
        ramp_duty = '0;
        test_nxt  = 1'b0;
        done      = 1'b1;
      end
    end else begin
      prev_err_nxt = err;
      integ_nxt    = integ_new;
    end
    ramp_nxt = ramp_duty;
  end

  always_comb begin
    data.test.is_test     = run;
    data.test.test_active = test_nxt;
    data.test.test_done   = done;
    data.test.ramp_duty   = ramp_duty;
    data.err              = err;
    data.derr             = derr;
    data.integ            = integ_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      test_r     <= 1'b0;
      ramp_r     <= '0;
      div_r      <= 2'd0;
      prev_err_r <= '0;
      integ_r    <= '0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (rdy_out) begin
        out_v_r <= in_v_r;
      end
      if (move) begin
        test_r     <= test_nxt;
        ramp_r     <= ramp_nxt;
        div_r      <= div_nxt;
        prev_err_r <= prev_err_nxt;
        integ_r    <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      meas_r  <= meas;
      start_r <= start;
    end
    if (move) begin
      out_r <= data;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_test_holds_integral: assert property (@(posedge clk) disable iff (!rst_n)
    test_r |=> $stable(integ_r))
    else $error("integral changed while the ramp test was running");

  a_divider_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_r != 2'd3)
    else $error("ramp divider reached an unused count");

endmodule

`default_nettype wire

@@ hdl/pdc_corr_pipe.sv @@
// Gain products, sum and truncating division by the PID scale, over three stages.
`default_nettype none

module pdc_corr_pipe (
  input  logic               clk,
  input  logic               rst_n,
  input  pdc_pkg::pdc_cfg_t  cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  pdc_pkg::pdc_ctrl_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pdc_pkg::pdc_corr_t out_data
);
  import pdc_pkg::*;

  logic                     v_a_r, v_b_r, v_c_r;
  logic                     rdy_a, rdy_b, rdy_c;
  pdc_test_t                test_a_r, test_b_r;
  logic signed [KP_W-1:0]   kp_p_r;
  logic signed [KI_W-1:0]   ki_p_r;
  logic signed [KD_W-1:0]   kd_p_r;
  logic                     neg_b_r, big_b_r;
  logic [MAG_W-1:0]         mag_b_r;
  pdc_corr_t                out_r;

  logic signed [KP_W-1:0]   kp_p;
  logic signed [KI_W-1:0]   ki_p;
  logic signed [KD_W-1:0]   kd_p;
  logic signed [SUM_W-1:0]  sum_s;
  logic [SUM_W-1:0]         mag;
  logic                     big;
  logic [PROD_W-1:0]        prod;
  logic [Q_W-1:0]           q_calc;

  assign rdy_c    = !v_c_r || out_ready;
  assign rdy_b    = !v_b_r || rdy_c;
  assign rdy_a    = !v_a_r || rdy_b;
  assign in_ready = rdy_a;

  assign kp_p = $signed({1'b0, cfg.kp}) * $signed(in_data.err);
  assign ki_p = $signed({1'b0, cfg.ki}) * $signed(in_data.integ);
  assign kd_p = $signed({1'b0, cfg.kd}) * $signed(in_data.derr);

  assign sum_s = SUM_W'(kp_p_r) + SUM_W'(ki_p_r) + SUM_W'(kd_p_r);
  assign mag   = sum_s[SUM_W-1] ? SUM_W'(-sum_s) : SUM_W'(sum_s);
  assign big   = mag >= SUM_W'(CORR_LIMIT);

  assign prod   = PROD_W'(mag_b_r) * PROD_W'(RECIP_MUL);
  assign q_calc = big_b_r ? Q_SAT : Q_W'(prod >> RECIP_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        v_a_r <= in_valid;
      end
      if (rdy_b) begin
        v_b_r <= v_a_r;
      end
      if (rdy_c) begin
        v_c_r <= v_b_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy_a) begin
      test_a_r <= in_data.test;
      kp_p_r   <= kp_p;
      ki_p_r   <= ki_p;
      kd_p_r   <= kd_p;
    end
    if (v_a_r && rdy_b) begin
      test_b_r <= test_a_r;
      neg_b_r  <= sum_s[SUM_W-1];
      big_b_r  <= big;
      mag_b_r  <= mag[MAG_W-1:0];
    end
    if (v_b_r && rdy_c) begin
      out_r.test  <= test_b_r;
      out_r.neg   <= neg_b_r;
      out_r.q_mag <= q_calc;
    end
  end

  assign out_valid = v_c_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ hdl/pid_pwm_duty_controller_core.sv @@
// Top level of the PID duty controller: configuration registers and the duty result stage.
//
// One input transfer per control tick carries a measured voltage in centivolts and
// a start_test flag; each one yields exactly one result transfer with the new duty,
// the test_active flag and the test_done flag, in order. Both channels use valid
// and ready. Configuration is written through cfg_we, cfg_addr and cfg_wdata with
// no wait state; indexes with no register are ignored.
// Throughput is one item per cycle while the receiver takes results: the error
// and integral update closes within the control stage, the duty update closes
// within the result stage, and the gain products, sum and division by the scale
// run in three stages between them. Every stage holds its item when the stage after
// it is full and stalled, so a stalled receiver fills the pipeline before in_ready
// falls; empty stages keep taking items while a result waits.
// Reset clears the pipeline, the duty, the error history, the integral and the
// test state, and loads the default setpoint, tolerance, gains and duty limit.
`default_nettype none

module pid_pwm_duty_controller_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pdc_pkg::VOLT_BITS-1:0]  in_measured_voltage,
  input  logic                           in_start_test,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pdc_pkg::DUTY_W-1:0]     out_duty,
  output logic                           out_test_active,
  output logic                           out_test_done,
  input  logic                           cfg_we,
  input  logic [pdc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pdc_pkg::CFG_W-1:0]      cfg_wdata
);
  import pdc_pkg::*;

  pdc_cfg_t            cfg_r;
  logic                out_v_r;
  logic [DUTY_W-1:0]   duty_r, duty_nxt;
  logic                active_r, done_r;

  logic                ctrl_valid, ctrl_ready;
  pdc_ctrl_t           ctrl_data;
  logic                corr_valid, corr_ready;
  pdc_corr_t           corr_data;
  logic                move;
  logic [NEXT_W-1:0]   pid_next;
  logic [DUTY_W-1:0]   pid_duty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint  <= SETPOINT_RST;
      cfg_r.tolerance <= TOLERANCE_RST;
      cfg_r.kp        <= KP_RST;
      cfg_r.ki        <= KI_RST;
      cfg_r.kd        <= KD_RST;
      cfg_r.duty_max  <= DUTY_MAX_RST;
    end else if (cfg_we) begin
      case (pdc_reg_t'(cfg_addr))
        REG_SETPOINT:  cfg_r.setpoint  <= cfg_wdata[VOLT_BITS-1:0];
        REG_TOLERANCE: cfg_r.tolerance <= cfg_wdata[VOLT_BITS-1:0];
        REG_KP:        cfg_r.kp        <= cfg_wdata[GAIN_W-1:0];
        REG_KI:        cfg_r.ki        <= cfg_wdata[GAIN_W-1:0];
        REG_KD:        cfg_r.kd        <= cfg_wdata[GAIN_W-1:0];
        REG_DUTY_MAX:  cfg_r.duty_max  <= cfg_wdata[DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pdc_ctrl_stage u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .meas      (in_measured_voltage),
    .start     (in_start_test),
    .out_valid (ctrl_valid),
    .out_ready (ctrl_ready),
    .out_data  (ctrl_data)
  );

  pdc_corr_pipe u_corr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (ctrl_valid),
    .in_ready  (ctrl_ready),
    .in_data   (ctrl_data),
    .out_valid (corr_valid),
    .out_ready (corr_ready),
    .out_data  (corr_data)
  );

  assign corr_ready = !out_v_r || out_ready;
  assign move       = corr_valid && corr_ready;

  assign pid_next = corr_data.neg ?
                    ({3'b000, duty_r} - {2'b00, corr_data.q_mag}) :
                    ({3'b000, duty_r} + {2'b00, corr_data.q_mag});

  always_comb begin
    if (pid_next[NEXT_W-1]) begin
      pid_duty = '0;
    end else if (pid_next > {3'b000, cfg_r.duty_max}) begin
      pid_duty = cfg_r.duty_max;
    end else begin
      pid_duty = pid_next[DUTY_W-1:0];
    end
  end

  assign duty_nxt = corr_data.test.is_test ? corr_data.test.ramp_duty : pid_duty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      duty_r   <= '0;
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      if (corr_ready) begin
        out_v_r <= corr_valid;
      end
      if (move) begin
        duty_r   <= duty_nxt;
        active_r <= corr_data.test.test_active;
        done_r   <= corr_data.test.test_done;
      end
    end
  end

  assign out_valid       = out_v_r;
  assign out_duty        = duty_r;
  assign out_test_active = active_r;
  assign out_test_done   = done_r;

  a_empty_output_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while the result register was empty");

  a_done_clears_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_test_done |-> (out_duty == '0) && !out_test_active)
    else $error("ramp test end did not clear the duty and the active flag");

  a_result_follows_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_valid)
    else $error("a result transfer into the output register was lost");

endmodule

`default_nettype wire

@@ sim/pid_pwm_duty_controller_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the PID duty controller core, with a scoreboard that predicts each tick.
module pid_pwm_duty_controller_core_test;
  import pdc_pkg::*;

  localparam int RANDOM_TICKS = 80;
  localparam int SAT_TICKS = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int VOLT_MAX = (1 << VOLT_BITS) - 1;
  localparam int DUTY_TOP = (1 << DUTY_W) - 1;
  localparam int GAIN_TOP = (1 << GAIN_W) - 1;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              test_active;
    logic              test_done;
  } duty_result_t;

  class duty_scoreboard;
    int setpoint, tolerance, kp, ki, kd, duty_max;
    int duty, prev_err, divider;
    longint integ;
    bit running;
    duty_result_t expected_q[$];
    int errors, checked;

    function new();
      setpoint = SETPOINT_RST;
      tolerance = TOLERANCE_RST;
      kp = KP_RST;
      ki = KI_RST;
      kd = KD_RST;
      duty_max = DUTY_MAX_RST;
      duty = 0;
      prev_err = 0;
      divider = 0;
      integ = 0;
      running = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
      case (addr)
        REG_SETPOINT:  setpoint = data[VOLT_BITS-1:0];
        REG_TOLERANCE: tolerance = data[VOLT_BITS-1:0];
        REG_KP:        kp = data[GAIN_W-1:0];
        REG_KI:        ki = data[GAIN_W-1:0];
        REG_KD:        kd = data[GAIN_W-1:0];
        REG_DUTY_MAX:  duty_max = data[DUTY_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_tick(logic [VOLT_BITS-1:0] meas, logic start);
      duty_result_t r;
      int err, derr;
      longint corr, next_duty;
      r.test_done = 1'b0;
      if (start && !running) begin
        running = 1'b1;
        duty = 0;
      end
      if (running) begin
        if (duty < duty_max) begin
          if (divider < 2) begin
            divider++;
          end else begin
            duty = duty + 1;
            divider = 0;
          end
        end else begin
          duty = 0;
          running = 1'b0;
          r.test_done = 1'b1;
        end
      end else begin
        err = setpoint - int'(meas);
        derr = err - prev_err;
        if (err < tolerance) begin
          integ = 0;
        end else begin
          integ += err;
          if (integ > longint'(INTEG_MAX)) integ = longint'(INTEG_MAX);
          if (integ < longint'(INTEG_MIN)) integ = longint'(INTEG_MIN);
        end
        prev_err = err;
        corr = (longint'(kp) * err + longint'(ki) * integ + longint'(kd) * derr) / PID_SCALE;
        next_duty = duty + corr;
        if (next_duty < 0) next_duty = 0;
        if (next_duty > duty_max) next_duty = duty_max;
        duty = int'(next_duty);
      end
      r.duty = DUTY_W'(duty);
      r.test_active = running;
      expected_q.push_back(r);
    endfunction

    function void compare(string field, logic [DUTY_W-1:0] want, logic [DUTY_W-1:0] got);
      if (got !== want) begin
        errors++;
        $error("%s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void match_result(duty_result_t got);
      duty_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result transfer with no tick pending: duty %0d", got.duty);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare("duty", want.duty, got.duty);
      compare("test_active", want.test_active, got.test_active);
      compare("test_done", want.test_done, got.test_done);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [VOLT_BITS-1:0] in_measured_voltage = '0;
  logic in_start_test = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DUTY_W-1:0] out_duty;
  logic out_test_active;
  logic out_test_done;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_SETPOINT;
  logic [CFG_W-1:0] cfg_wdata = '0;
  bit calm = 1'b0;
  int quiet_cycles = 0;
  duty_scoreboard sb;

  pid_pwm_duty_controller_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_measured_voltage (in_measured_voltage),
    .in_start_test       (in_start_test),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_duty            (out_duty),
    .out_test_active     (out_test_active),
    .out_test_done       (out_test_done),
    .cfg_we              (cfg_we),
    .cfg_addr            (cfg_addr),
    .cfg_wdata           (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    duty_result_t got;
    got.duty = out_duty;
    got.test_active = out_test_active;
    got.test_done = out_test_done;
    if (rst_n && in_valid && in_ready) sb.take_tick(in_measured_voltage, in_start_test);
    if (rst_n && out_valid && out_ready) sb.match_result(got);
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("pid_pwm_duty_controller_core_test: errors");
      $finish;
    end
  end

  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && !calm && sb.checked >= 200) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 22);
    end
  end

  task automatic send_tick(input int volts, input bit start);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_measured_voltage <= VOLT_BITS'(volts);
    in_start_test <= start;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= CFG_W'(data);
    @(posedge clk);
    sb.write_reg(addr, CFG_W'(data));
  endtask

  task automatic settle_and_program(input int sp, input int tol, input int kp, input int ki,
                                    input int kd, input int dmax);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_TOLERANCE, tol);
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_DUTY_MAX, dmax);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int phase, i, volts;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Default settings: extremes of the voltage and both sides of the tolerance.
    send_tick(0, 1'b0);
    send_tick(VOLT_MAX, 1'b0);
    send_tick(550, 1'b0);
    send_tick(500, 1'b0);
    send_tick(501, 1'b0);
    send_tick(499, 1'b0);
    send_tick(1023, 1'b0);
    send_tick(0, 1'b0);

    // A short ramp test; a second start while it runs must be ignored.
    settle_and_program(550, 50, 5, 2, 3, 3);
    for (i = 0; i < 11; i++) send_tick($urandom_range(VOLT_MAX), i == 0 || i == 5);

    // With a zero duty limit a started test ends on the same tick.
    settle_and_program(VOLT_MAX, 0, GAIN_TOP, GAIN_TOP, GAIN_TOP, 0);
    write_reg(REG_UNUSED, $urandom_range(VOLT_MAX));
    cfg_we <= 1'b0;
    send_tick(0, 1'b1);
    send_tick(VOLT_MAX, 1'b1);
    send_tick(0, 1'b0);
    send_tick(VOLT_MAX, 1'b0);

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: settle_and_program(VOLT_MAX, VOLT_MAX, GAIN_TOP, GAIN_TOP, GAIN_TOP, DUTY_TOP);
        1: settle_and_program(0, 0, 0, 0, 0, 0);
        default: settle_and_program($urandom_range(VOLT_MAX), $urandom_range(300),
                                    $urandom_range(VOLT_MAX), $urandom_range(VOLT_MAX),
                                    $urandom_range(VOLT_MAX),
                                    ($urandom_range(3) == 0) ? $urandom_range(DUTY_TOP)
                                                             : $urandom_range(60));
      endcase
      calm = (phase == 4);
      for (i = 0; i < RANDOM_TICKS; i++) begin
        case ($urandom_range(9))
          0: volts = 0;
          1: volts = VOLT_MAX;
          2, 3, 4: volts = $urandom_range(VOLT_MAX);
          default: begin
            volts = sb.setpoint + int'($urandom_range(200)) - 100;
            if (volts < 0) volts = 0;
            if (volts > VOLT_MAX) volts = VOLT_MAX;
          end
        endcase
        send_tick(volts, $urandom_range(99) < 2);
      end
    end

    // Hold the largest error on every tick so the integral keeps growing.
    settle_and_program(VOLT_MAX, 0, $urandom_range(GAIN_TOP), $urandom_range(GAIN_TOP),
                       $urandom_range(GAIN_TOP), $urandom_range(DUTY_TOP));
    calm = 1'b1;
    for (i = 0; i < SAT_TICKS; i++) send_tick(0, 1'b0);
    for (i = 0; i < 20; i++) send_tick($urandom_range(VOLT_MAX), 1'b0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("pid_pwm_duty_controller_core_test: clean");
    end else begin
      $display("pid_pwm_duty_controller_core_test: errors");
    end
    $finish;
  end

endmodule
